[hdl/sis_pkg.sv]
// Shared types and constants for the kinetic scroll step core.
// No dependencies; every other file but sis_chk refers to it by scoped name.
package sis_pkg;

    localparam int WORD_W    = 32;
    localparam int KIND_W    = 3;
    localparam int FT_W      = 20;
    localparam int CFG_IDX_W = 3;
    localparam int SF_W      = 31;
    localparam int COEF_W    = 16;
    localparam int DRAG_W    = 32;
    localparam int RATE_W    = 16;

    // Internal datapath: wide enough for any position sum or Q2.14 product
    localparam int WIDE_W  = 54;
    localparam int Q_FRAC  = 14;
    localparam int MUL_C_W = 18;
    localparam int MUL_H_W = 24;
    localparam int MUL_X_W = MUL_H_W + 1;
    localparam int MUL_Y_W = MUL_C_W + 1;
    localparam int PROD_W  = MUL_X_W + MUL_Y_W;
    localparam int SUM_W   = WIDE_W + Q_FRAC;

    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_wide MUL_LIM = 54'sh0_4000_0000_0000;
    localparam logic [Q_FRAC-1:0] Q_HALF = 14'd8192;

    // frame ratio = floor(us * 3072 / 3125) via reciprocal, exact for us <= 50000
    localparam int RATE_SHIFT = 28;
    localparam logic [RATE_SHIFT-1:0] RATE_K      = 28'd263882791;
    localparam logic [RATE_W-1:0]     RATE_US_MAX = 16'd50000;
    localparam logic [RATE_W-1:0]     RATE_MAX    = 16'd49152;

    localparam logic [SF_W-1:0]   SF_RESET   = 31'd2560;
    localparam logic [COEF_W-1:0] EDGE_RESET = 16'd8192;
    localparam logic [COEF_W-1:0] PULL_RESET = 16'd4096;
    localparam logic [COEF_W-1:0] DYN_RESET  = 16'd15565;

    typedef enum logic [KIND_W-1:0] {
        KIND_TOUCH   = 3'd0,
        KIND_RELEASE = 3'd1,
        KIND_DRAG    = 3'd2,
        KIND_MOVE_TO = 3'd3,
        KIND_UPDATE  = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_POS     = 3'd0,
        CFG_MAX_POS     = 3'd1,
        CFG_STATIC_FRIC = 3'd2,
        CFG_EDGE_ATT    = 3'd3,
        CFG_PULL_BACK   = 3'd4,
        CFG_DYN_FRIC    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [WORD_W-1:0] min_pos;
        logic signed [WORD_W-1:0] max_pos;
        logic [SF_W-1:0]          static_fric;
        logic [COEF_W-1:0]        edge_att;
        logic [COEF_W-1:0]        pull_back;
        logic [COEF_W-1:0]        dyn_fric;
    } t_cfg;

    typedef struct packed {
        logic               start;
        t_wide              a;
        logic [MUL_C_W-1:0] c;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_wide res;
    } t_mul_rsp;

endpackage

[hdl/sis_if.sv]
// Valid/ready channel interfaces: event input, result output, register writes.
// Depends on sis_pkg for field widths.
interface sis_in_if;
    logic                               valid;
    logic                               ready;
    logic [sis_pkg::KIND_W-1:0]         kind;
    logic signed [sis_pkg::WORD_W-1:0]  value;
    logic [sis_pkg::FT_W-1:0]           frame_time;

    modport source (output valid, kind, value, frame_time, input ready);
    modport sink   (input valid, kind, value, frame_time, output ready);
endinterface

interface sis_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sis_pkg::WORD_W-1:0]  position;
    logic signed [sis_pkg::WORD_W-1:0]  speed;
    logic                               touching;

    modport source (output valid, position, speed, touching, input ready);
    modport sink   (input valid, position, speed, touching, output ready);
endinterface

interface sis_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sis_pkg::CFG_IDX_W-1:0]      index;
    logic [sis_pkg::WORD_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/sis_cfg.sv]
// Configuration register file: bounds, static friction and Q2.14 coefficients.
// Depends on sis_pkg and sis_cfg_if.
module sis_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sis_cfg_if.sink         i_cfg,
    output sis_pkg::t_cfg   o_cfg
);

    sis_pkg::t_cfg r_cfg;
    sis_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sis_pkg::CFG_MIN_POS:     n_cfg.min_pos     = i_cfg.data;
                sis_pkg::CFG_MAX_POS:     n_cfg.max_pos     = i_cfg.data;
                sis_pkg::CFG_STATIC_FRIC: n_cfg.static_fric = i_cfg.data[sis_pkg::SF_W-1:0];
                sis_pkg::CFG_EDGE_ATT:    n_cfg.edge_att    = i_cfg.data[sis_pkg::COEF_W-1:0];
                sis_pkg::CFG_PULL_BACK:   n_cfg.pull_back   = i_cfg.data[sis_pkg::COEF_W-1:0];
                sis_pkg::CFG_DYN_FRIC:    n_cfg.dyn_fric    = i_cfg.data[sis_pkg::COEF_W-1:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_pos     <= '0;
            r_cfg.max_pos     <= '0;
            r_cfg.static_fric <= sis_pkg::SF_RESET;
            r_cfg.edge_att    <= sis_pkg::EDGE_RESET;
            r_cfg.pull_back   <= sis_pkg::PULL_RESET;
            r_cfg.dyn_fric    <= sis_pkg::DYN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[hdl/sis_mul.sv]
// Shared Q2.14 multiplier: clamps the multiplicand to +-2^46, then one 25x19
// multiplier forms the high partial product, then the low one. Uses sis_pkg.
module sis_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sis_pkg::t_mul_req   i_req,
    output sis_pkg::t_mul_rsp   o_rsp
);

    sis_pkg::t_wide                         a_cl;
    logic signed [sis_pkg::MUL_H_W-1:0]     r_a_hi;
    logic [sis_pkg::MUL_H_W-1:0]            r_a_lo;
    logic [sis_pkg::MUL_C_W-1:0]            r_c;
    logic signed [sis_pkg::PROD_W-1:0]      r_acc;
    sis_pkg::t_wide                         r_res;
    logic                                   r_ph_hi;
    logic                                   r_ph_lo;
    logic                                   r_done;

    logic signed [sis_pkg::MUL_X_W-1:0]     mul_x;
    logic signed [sis_pkg::MUL_Y_W-1:0]     mul_y;
    logic signed [sis_pkg::PROD_W-1:0]      prod;
    logic signed [sis_pkg::SUM_W-1:0]       sum;

    always_comb begin
        if (i_req.a > sis_pkg::MUL_LIM) begin
            a_cl = sis_pkg::MUL_LIM;
        end else if (i_req.a < -sis_pkg::MUL_LIM) begin
            a_cl = -sis_pkg::MUL_LIM;
        end else begin
            a_cl = i_req.a;
        end
    end

    assign mul_x = r_ph_hi ? {r_a_hi[sis_pkg::MUL_H_W-1], r_a_hi} : {1'b0, r_a_lo};
    assign mul_y = {1'b0, r_c};
    assign prod  = mul_x * mul_y;
    // round to nearest, ties up: add half then floor by arithmetic shift
    assign sum   = (sis_pkg::SUM_W'(r_acc) <<< sis_pkg::MUL_H_W) + sis_pkg::SUM_W'(prod)
                 + sis_pkg::SUM_W'(sis_pkg::Q_HALF);

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a_hi <= a_cl[2*sis_pkg::MUL_H_W-1:sis_pkg::MUL_H_W];
            r_a_lo <= a_cl[sis_pkg::MUL_H_W-1:0];
            r_c    <= i_req.c;
        end
        if (r_ph_hi) begin
            r_acc <= prod;
        end
        if (r_ph_lo) begin
            r_res <= sum[sis_pkg::SUM_W-1:sis_pkg::Q_FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_hi <= 1'b0;
            r_ph_lo <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_ph_hi <= i_req.start;
            r_ph_lo <= r_ph_hi;
            r_done  <= r_ph_lo;
        end
    end

endmodule

[hdl/scroll_inertia_step_core.sv]
// Kinetic scroll step core: event sequencer, scroll state and result register.
// Depends on sis_pkg, sis_if, sis_cfg and sis_mul.
//
//  channel  | dir | handshake     | word
//  i_in     | in  | valid/ready   | kind, value, frame_time
//  o_out    | out | valid/ready   | position, speed, touching
//  i_cfg    | in  | valid/ready   | index, data (always ready)
//
// One event at a time. Touch, release, drag, move-to, a held update without
// attenuation and a released update that just stops need no product; a held
// update with edge attenuation takes one product in the shared multiplier, and
// a released update that springs back or coasts takes a ratio step, then three
// products there. Synchronous reset zeroes state and loads register defaults, no
// clearing pass. A finished word waits in the result register; the core holds
// the next result until the waiting word is taken.
module scroll_inertia_step_core #(
    parameter int POS_WIDTH = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sis_in_if.sink      i_in,
    sis_out_if.source   o_out,
    sis_cfg_if.sink     i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_RATE = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        STEP_A = 3'b001,
        STEP_B = 3'b010,
        STEP_C = 3'b100
    } t_step;

    localparam sis_pkg::t_wide POS_HI =
        (sis_pkg::t_wide'(1) <<< (POS_WIDTH - 1)) - sis_pkg::t_wide'(1);
    localparam sis_pkg::t_wide POS_LO = -POS_HI - sis_pkg::t_wide'(1);
    localparam sis_pkg::t_wide HALF   = sis_pkg::t_wide'(1) <<< (FRAC_BITS - 1);

    function automatic sis_pkg::t_wide sat_pos(input sis_pkg::t_wide v);
        if (v > POS_HI) begin
            return POS_HI;
        end else if (v < POS_LO) begin
            return POS_LO;
        end
        return v;
    endfunction

    sis_pkg::t_cfg      cfg;
    sis_pkg::t_mul_req  mul_req;
    sis_pkg::t_mul_rsp  mul_rsp;

    t_state r_state, n_state;
    t_step  r_step, n_step;

    logic signed [POS_WIDTH-1:0]            r_pos, n_pos;
    logic signed [POS_WIDTH-1:0]            r_speed, n_speed;
    logic signed [POS_WIDTH-1:0]            r_prev, n_prev;
    logic [sis_pkg::DRAG_W-1:0]             r_drag, n_drag;
    logic                                   r_held, n_held;

    logic [sis_pkg::KIND_W-1:0]             r_kind, n_kind;
    logic signed [sis_pkg::WORD_W-1:0]      r_val, n_val;
    logic [sis_pkg::FT_W-1:0]               r_ft, n_ft;
    logic [sis_pkg::RATE_W-1:0]             r_rate, n_rate;

    logic                                   r_out_valid, n_out_valid;
    logic signed [sis_pkg::WORD_W-1:0]      r_o_pos, n_o_pos;
    logic signed [sis_pkg::WORD_W-1:0]      r_o_speed, n_o_speed;
    logic                                   r_o_touch, n_o_touch;

    sis_pkg::t_wide pos_w, speed_w, val_w, min_w, max_w, bound_w, diff_w;
    sis_pkg::t_wide drag_speed, drag_pos, move_pos, held_pos;
    sis_pkg::t_wide m_sat, att_pos, coast_pos;
    logic           below, above, oob, coast;
    logic [sis_pkg::DRAG_W:0]               mag, drag_sum;
    logic [sis_pkg::DRAG_W-1:0]             drag_next;
    logic [sis_pkg::RATE_W+sis_pkg::RATE_SHIFT-1:0] rate_prod;
    logic [sis_pkg::RATE_W-1:0]             rate_val;
    logic [sis_pkg::MUL_C_W-1:0]            rate_c;

    sis_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    sis_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign pos_w   = sis_pkg::t_wide'(r_pos);
    assign speed_w = sis_pkg::t_wide'(r_speed);
    assign val_w   = sis_pkg::t_wide'(r_val);
    assign min_w   = sis_pkg::t_wide'(cfg.min_pos);
    assign max_w   = sis_pkg::t_wide'(cfg.max_pos);

    // below-min wins when the bounds are crossed
    assign below   = pos_w < min_w;
    assign above   = pos_w > max_w;
    assign oob     = below || above;
    assign bound_w = below ? min_w : max_w;
    assign diff_w  = bound_w - pos_w;
    assign coast   = (speed_w >= HALF) || (speed_w <= -HALF);

    assign mag       = r_val[sis_pkg::WORD_W-1] ?
                       ((sis_pkg::DRAG_W+1)'(0) - (sis_pkg::DRAG_W+1)'(val_w)) :
                       (sis_pkg::DRAG_W+1)'(val_w);
    assign drag_sum  = {1'b0, r_drag} + mag;
    assign drag_next = drag_sum[sis_pkg::DRAG_W] ? '1 : drag_sum[sis_pkg::DRAG_W-1:0];

    assign rate_prod = r_ft[sis_pkg::RATE_W-1:0] * sis_pkg::RATE_K;
    assign rate_val  = (r_ft > sis_pkg::FT_W'(sis_pkg::RATE_US_MAX)) ? sis_pkg::RATE_MAX :
                       rate_prod[sis_pkg::RATE_W+sis_pkg::RATE_SHIFT-1:sis_pkg::RATE_SHIFT];
    assign rate_c    = sis_pkg::MUL_C_W'(r_rate);

    assign drag_speed = sat_pos(speed_w + val_w);
    assign drag_pos   = sat_pos(pos_w + val_w);
    assign move_pos   = sat_pos(val_w);
    assign held_pos   = sat_pos(pos_w + speed_w);
    assign m_sat      = sat_pos(mul_rsp.res);
    assign att_pos    = sat_pos(pos_w + m_sat);
    assign coast_pos  = sat_pos(pos_w + mul_rsp.res);

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.position = r_o_pos;
    assign o_out.speed    = r_o_speed;
    assign o_out.touching = r_o_touch;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_pos       = r_pos;
        n_speed     = r_speed;
        n_prev      = r_prev;
        n_drag      = r_drag;
        n_held      = r_held;
        n_kind      = r_kind;
        n_val       = r_val;
        n_ft        = r_ft;
        n_rate      = r_rate;
        n_out_valid = r_out_valid;
        n_o_pos     = r_o_pos;
        n_o_speed   = r_o_speed;
        n_o_touch   = r_o_touch;
        mul_req     = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind  = i_in.kind;
                    n_val   = i_in.value;
                    n_ft    = i_in.frame_time;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_kind)
                    sis_pkg::KIND_TOUCH: begin
                        n_held  = 1'b1;
                        n_speed = '0;
                        n_prev  = '0;
                        n_drag  = '0;
                    end
                    sis_pkg::KIND_RELEASE: begin
                        n_held  = 1'b0;
                        n_speed = r_prev;
                        n_drag  = '0;
                    end
                    sis_pkg::KIND_DRAG: begin
                        if (r_held) begin
                            n_speed = drag_speed[POS_WIDTH-1:0];
                            n_drag  = drag_next;
                        end else begin
                            n_pos = drag_pos[POS_WIDTH-1:0];
                        end
                    end
                    sis_pkg::KIND_MOVE_TO: begin
                        n_pos   = move_pos[POS_WIDTH-1:0];
                        n_speed = '0;
                        n_prev  = '0;
                    end
                    sis_pkg::KIND_UPDATE: begin
                        if (r_held) begin
                            if (r_drag >= {1'b0, cfg.static_fric}) begin
                                if (oob) begin
                                    mul_req.start = 1'b1;
                                    mul_req.a     = speed_w;
                                    mul_req.c     = sis_pkg::MUL_C_W'(cfg.edge_att);
                                    n_state       = S_MUL;
                                end else begin
                                    n_pos   = held_pos[POS_WIDTH-1:0];
                                    n_prev  = r_speed;
                                    n_speed = '0;
                                end
                            end else begin
                                n_prev = '0;
                            end
                        end else begin
                            n_prev = r_speed;
                            n_rate = rate_val;
                            if (oob || coast) begin
                                n_state = S_RATE;
                            end else begin
                                n_speed = '0;
                            end
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_RATE: begin
                mul_req.start = 1'b1;
                if (oob) begin
                    mul_req.a = diff_w;
                    mul_req.c = sis_pkg::MUL_C_W'(cfg.pull_back);
                end else begin
                    mul_req.a = sis_pkg::t_wide'(r_rate);
                    mul_req.c = sis_pkg::MUL_C_W'(cfg.dyn_fric);
                end
                n_step  = STEP_A;
                n_state = S_MUL;
            end
            S_MUL: begin
                if (mul_rsp.done) begin
                    if (r_held) begin
                        // attenuated touch movement
                        n_pos   = att_pos[POS_WIDTH-1:0];
                        n_prev  = m_sat[POS_WIDTH-1:0];
                        n_speed = '0;
                        n_state = S_DONE;
                    end else begin
                        unique case (r_step)
                            STEP_A: begin
                                mul_req.start = 1'b1;
                                if (oob) begin
                                    mul_req.a = mul_rsp.res;
                                    mul_req.c = rate_c;
                                end else begin
                                    mul_req.a = speed_w;
                                    mul_req.c = mul_rsp.res[sis_pkg::MUL_C_W-1:0];
                                end
                                n_step = STEP_B;
                            end
                            STEP_B: begin
                                n_speed       = m_sat[POS_WIDTH-1:0];
                                mul_req.start = 1'b1;
                                mul_req.a     = m_sat;
                                mul_req.c     = rate_c;
                                n_step        = STEP_C;
                            end
                            STEP_C: begin
                                n_pos   = coast_pos[POS_WIDTH-1:0];
                                n_state = S_DONE;
                            end
                            default: n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_o_pos     = pos_w[sis_pkg::WORD_W-1:0];
                    n_o_speed   = speed_w[sis_pkg::WORD_W-1:0];
                    n_o_touch   = r_held;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_A;
            r_pos       <= '0;
            r_speed     <= '0;
            r_prev      <= '0;
            r_drag      <= '0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pos       <= n_pos;
            r_speed     <= n_speed;
            r_prev      <= n_prev;
            r_drag      <= n_drag;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_val     <= n_val;
        r_ft      <= n_ft;
        r_rate    <= n_rate;
        r_o_pos   <= n_o_pos;
        r_o_speed <= n_o_speed;
        r_o_touch <= n_o_touch;
    end

endmodule

[hdl/sis_chk.sv]
// Port-level checks for the scroll step core, attached to it by bind.
// Depends only on the top level's channel signals.
module sis_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_position,
    input logic [31:0] i_out_speed,
    input logic        i_out_touching
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready straight after an accepted word");

    a_result_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result word appeared without the core being busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_position) && $stable(i_out_speed)
             && $stable(i_out_touching)))
        else $error("stalled result word changed");

endmodule

bind scroll_inertia_step_core sis_chk u_sis_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_position (o_out.position),
    .i_out_speed    (o_out.speed),
    .i_out_touching (o_out.touching)
);
